// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks used by the file that asserts.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off while reset is asserted.
`define LBPE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lbpe assertion failed");

// Next-cycle implication, gated off while reset is asserted.
`define LBPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lbpe assertion failed");

`endif

// ----- src/lbpe_pkg.sv -----
// ---------------------------------------------------------------------------
// lbpe_pkg
// Types, constants and codes shared by the LED blink priority engine.
// ---------------------------------------------------------------------------
package lbpe_pkg;

	localparam int SLOTS     = 8;
	localparam int TIME_BITS = 16;
	localparam int SLOT_IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef logic [SLOT_IW-1:0]   slot_idx_t;
	typedef logic [TIME_BITS-1:0] time_t;

	localparam slot_idx_t SLOT_LAST = SLOT_IW'(SLOTS - 1);
	localparam time_t     TIME_MASK = '1;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_ADD  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_BLINK = 2'd0,
		KIND_ON    = 2'd1,
		KIND_OFF   = 2'd2
	} kind_t;

	typedef struct packed {
		logic        op;
		logic [7:0]  priority_req;
		logic [1:0]  kind;
		logic [15:0] on_ticks;
		logic [15:0] off_ticks;
		logic [15:0] flash_count;
		logic        count_forever;
		logic        start_off;
	} req_t;

	typedef struct packed {
		logic        led_on;
		logic        has_pattern;
		logic [7:0]  top_priority;
		logic [15:0] top_count;
		logic        top_forever;
		logic [15:0] top_on_ticks;
		logic [15:0] top_off_ticks;
		logic        add_dropped;
	} rsp_t;

	// One table entry
	typedef struct packed {
		logic [7:0]  prio;
		logic        blink;
		logic        phase_on;
		time_t       on_time;
		time_t       off_time;
		time_t       ticks_left;
		logic [15:0] toggles;
		logic        endless;
		logic [15:0] ident;
	} slot_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_WALK,
		ST_RESULT
	} lbpe_state_t;

	typedef struct packed {
		logic      capture;
		logic      scan_step;
		logic      write_en;
		logic      walk_step;
		logic      last;
		logic      rd_top;
		logic      load_result;
		slot_idx_t idx;
	} lbpe_cmd_t;

	typedef struct packed {
		logic req_op;
		logic rsp_busy;
	} lbpe_status_t;

endpackage

// ----- src/lbpe_req_if.sv -----
// ---------------------------------------------------------------------------
// lbpe_req_if
// Request channel: valid/ready with one request item as payload.
// ---------------------------------------------------------------------------
interface lbpe_req_if import lbpe_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/lbpe_rsp_if.sv -----
// ---------------------------------------------------------------------------
// lbpe_rsp_if
// Response channel: valid/ready with one result item as payload.
// ---------------------------------------------------------------------------
interface lbpe_rsp_if import lbpe_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/lbpe_ctrl.sv -----
// ---------------------------------------------------------------------------
// lbpe_ctrl
// Sequencer: steps the slot index through the add scan or the tick walk.
// ---------------------------------------------------------------------------
module lbpe_ctrl import lbpe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  lbpe_status_t status,
	output lbpe_cmd_t    cmd
);

	lbpe_state_t state_q, state_d;
	slot_idx_t   idx_q;
	logic        last;

	assign last = (idx_q == SLOT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				idx_q <= '0;
			end else if (cmd.scan_step || cmd.walk_step) begin
				idx_q <= last ? '0 : idx_q + slot_idx_t'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (op_t'(status.req_op) == OP_ADD) ? ST_SCAN : ST_WALK;
				end
			end
			ST_SCAN: begin
				if (last) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				state_d = ST_RESULT;
			end
			ST_WALK: begin
				if (last) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!status.rsp_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.idx      = idx_q;
		cmd.last     = last;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ST_WRITE: begin
				cmd.write_en = 1'b1;
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
			end
			ST_RESULT: begin
				cmd.rd_top      = 1'b1;
				cmd.load_result = !status.rsp_busy;
			end
			default: begin
				cmd.capture = 1'b0;
			end
		endcase
	end

endmodule

// ----- src/lbpe_dpath.sv -----
// ---------------------------------------------------------------------------
// lbpe_dpath
// Slot table, top tracking, LED state and the result register.
// ---------------------------------------------------------------------------
module lbpe_dpath import lbpe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  req_t         req_data,
	input  lbpe_cmd_t    cmd,
	output lbpe_status_t status,
	lbpe_rsp_if.source   rsp
);

	slot_t       slot_q [SLOTS];
	logic [SLOTS-1:0] valid_q;

	req_t        in_q;
	logic        dropped_q;
	logic        match_found_q, free_found_q;
	slot_idx_t   match_idx_q, free_idx_q;
	logic        top_valid_q;
	slot_idx_t   top_idx_q;
	logic [7:0]  top_pri_q;
	logic        best_valid_q;
	slot_idx_t   best_idx_q;
	logic [7:0]  best_pri_q;
	logic        led_q;
	logic [15:0] shown_q;
	logic [15:0] ident_q;
	rsp_t        rsp_q;
	logic        rsp_valid_q;

	slot_idx_t   rd_addr;
	slot_t       rd;
	logic        rd_v;

	// walk update of the addressed slot
	slot_t       upd;
	logic        upd_v;
	logic        is_top;
	logic        led_d;
	logic [15:0] shown_d;
	time_t       tl;
	logic        cand;

	// add target
	logic        tgt_ok;
	slot_idx_t   tgt;
	slot_t       add_e;

	logic        wr_en;
	slot_idx_t   wr_addr;
	slot_t       wr_data;
	logic        wr_valid;

	assign status.req_op   = req_data.op;
	assign status.rsp_busy = rsp_valid_q && !rsp.ready;
	assign rsp.valid       = rsp_valid_q;
	assign rsp.data        = rsp_q;

	assign rd_addr = cmd.rd_top ? top_idx_q : cmd.idx;
	assign rd      = slot_q[rd_addr];
	assign rd_v    = valid_q[rd_addr];

	always_comb begin
		upd     = rd;
		upd_v   = rd_v;
		led_d   = led_q;
		shown_d = shown_q;
		tl      = rd.ticks_left;
		is_top  = top_valid_q && (top_idx_q == cmd.idx);
		if (rd_v) begin
			if (is_top && (shown_q != rd.ident)) begin
				shown_d = rd.ident;
				led_d   = rd.phase_on;
			end
			if (rd.blink) begin
				if (tl != '0) begin
					tl = tl - time_t'(1);
				end
				upd.ticks_left = tl;
				if (tl == '0) begin
					if (is_top) begin
						led_d = !rd.phase_on;
					end
					if (!rd.endless && (rd.toggles == 16'd0)) begin
						upd_v = 1'b0;
					end else begin
						if (!rd.endless) begin
							upd.toggles = rd.toggles - 16'd1;
						end
						upd.ticks_left = rd.phase_on ? rd.off_time : rd.on_time;
						upd.phase_on   = !rd.phase_on;
					end
				end
			end else if (is_top) begin
				led_d = rd.phase_on;
			end
		end
		// fold the updated slot into the search for the new top
		cand = upd_v && (!best_valid_q || (upd.prio > best_pri_q));
	end

	always_comb begin
		tgt_ok = match_found_q || free_found_q;
		tgt    = match_found_q ? match_idx_q : free_idx_q;

		add_e            = '0;
		add_e.prio       = in_q.priority_req;
		add_e.ident      = ident_q + 16'd1;
		add_e.toggles    = in_q.flash_count;
		add_e.endless    = in_q.count_forever;
		add_e.ticks_left = '0;
		case (in_q.kind)
			KIND_BLINK: begin
				add_e.blink    = 1'b1;
				add_e.on_time  = TIME_BITS'(in_q.on_ticks);
				add_e.off_time = TIME_BITS'(in_q.off_ticks);
				add_e.phase_on = in_q.start_off;
			end
			KIND_ON: begin
				add_e.blink    = 1'b0;
				add_e.on_time  = TIME_MASK;
				add_e.off_time = '0;
				add_e.phase_on = 1'b1;
			end
			default: begin
				add_e.blink    = 1'b0;
				add_e.on_time  = '0;
				add_e.off_time = TIME_MASK;
				add_e.phase_on = 1'b0;
			end
		endcase
	end

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = cmd.idx;
		wr_data  = upd;
		wr_valid = upd_v;
		if (cmd.walk_step) begin
			wr_en = 1'b1;
		end else if (cmd.write_en && tgt_ok) begin
			wr_en    = 1'b1;
			wr_addr  = tgt;
			wr_data  = add_e;
			wr_valid = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= req_data;
		end
		if (cmd.load_result) begin
			rsp_q.led_on        <= led_q;
			rsp_q.has_pattern   <= top_valid_q;
			rsp_q.top_priority  <= top_valid_q ? rd.prio : 8'd0;
			rsp_q.top_count     <= top_valid_q ? rd.toggles : 16'd0;
			rsp_q.top_forever   <= top_valid_q && rd.endless;
			rsp_q.top_on_ticks  <= top_valid_q ? 16'(rd.on_time) : 16'd0;
			rsp_q.top_off_ticks <= top_valid_q ? 16'(rd.off_time) : 16'd0;
			rsp_q.add_dropped   <= dropped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			top_valid_q   <= 1'b0;
			top_idx_q     <= '0;
			top_pri_q     <= '0;
			best_valid_q  <= 1'b0;
			best_idx_q    <= '0;
			best_pri_q    <= '0;
			match_found_q <= 1'b0;
			match_idx_q   <= '0;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			dropped_q     <= 1'b0;
			led_q         <= 1'b0;
			shown_q       <= '0;
			ident_q       <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= wr_valid;
			end

			if (cmd.capture) begin
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
				best_valid_q  <= 1'b0;
				dropped_q     <= 1'b0;
			end

			// first equal-priority entry, else lowest free slot
			if (cmd.scan_step) begin
				if (rd_v && (rd.prio == in_q.priority_req) && !match_found_q) begin
					match_found_q <= 1'b1;
					match_idx_q   <= cmd.idx;
				end
				if (!rd_v && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= cmd.idx;
				end
			end

			if (cmd.write_en) begin
				if (tgt_ok) begin
					ident_q <= add_e.ident;
					if (!top_valid_q || (in_q.priority_req > top_pri_q)) begin
						top_valid_q <= 1'b1;
						top_idx_q   <= tgt;
						top_pri_q   <= in_q.priority_req;
					end
				end else begin
					dropped_q <= 1'b1;
				end
			end

			if (cmd.walk_step) begin
				led_q   <= led_d;
				shown_q <= shown_d;
				if (cand) begin
					best_valid_q <= 1'b1;
					best_idx_q   <= cmd.idx;
					best_pri_q   <= upd.prio;
				end
				// hand the finished search over as the new top
				if (cmd.last) begin
					top_valid_q <= cand || best_valid_q;
					top_idx_q   <= cand ? cmd.idx : best_idx_q;
					top_pri_q   <= cand ? upd.prio : best_pri_q;
				end
			end

			if (cmd.load_result) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/led_blink_priority_engine.sv -----
// ---------------------------------------------------------------------------
// led_blink_priority_engine
// Priority table of LED blink patterns; one result per request item.
// ---------------------------------------------------------------------------
//  channel  dir  payload  transfer on
//  req      in   req_t    req.valid && req.ready
//  rsp      out  rsp_t    rsp.valid && rsp.ready
//
// A tick runs accept, a walk of one slot per cycle, then result;
// an add runs accept, scan, write, then result.
// The slot table has a single read port and a single write port.
// Reset clears the valid bits, top tracking, LED level and ident counters.
// A result waits in the output register; a new item is taken meanwhile,
// and the block holds in its result step only while that register is full and not taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module led_blink_priority_engine import lbpe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lbpe_req_if.sink   req,
	lbpe_rsp_if.source rsp
);

	lbpe_cmd_t    cmd;
	lbpe_status_t status;
	logic         in_ready;

	assign req.ready = in_ready;

	lbpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	lbpe_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req.data),
		.cmd      (cmd),
		.status   (status),
		.rsp      (rsp)
	);

	`LBPE_ASSERT_SAME(a_no_overwrite, clk, arst_n, cmd.load_result, !status.rsp_busy)
	`LBPE_ASSERT_NEXT(a_result_shown, clk, arst_n, cmd.load_result, rsp.valid)
	`LBPE_ASSERT_NEXT(a_busy_after_transfer, clk, arst_n, req.valid && req.ready, !req.ready)
	`LBPE_ASSERT_SAME(a_write_after_scan, clk, arst_n, cmd.write_en, $past(cmd.scan_step))

endmodule
